// ===== rtl/core/bfp_pkg.sv =====
// Shared widths and types of the LSB-first bit-field packer.
`default_nettype none
package bfp_pkg;

  localparam int ValueBits = 32;
  localparam int WidthBits = 6;
  localparam int AddrBits  = 16;
  localparam int CapBits   = 16;
  localparam int PosBits   = 19;
  localparam int PendBits  = 7;
  localparam int MaxBytes  = 4;

  typedef logic [7:0] byte_t;

  // Results of one input word, handed to the output serializer.
  typedef struct packed {
    logic                        has_bytes;
    logic                        ovf;
    logic [1:0]                  last_idx;
    logic [AddrBits-1:0]         base;
    byte_t [MaxBytes-1:0]        bytes;
  } grp_t;

endpackage
`default_nettype wire

// ===== rtl/core/bfp_ifs.sv =====
// Channel interfaces of the bit-field packer: config, input item, result.
`default_nettype none
interface bfp_cfg_if;
  import bfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CapBits-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bfp_item_if;
  import bfp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [ValueBits-1:0] field_value;
  logic [WidthBits-1:0] field_width;
  modport source (output valid, output kind, output field_value, output field_width,
                  input ready);
  modport sink (input valid, input kind, input field_value, input field_width,
                output ready);
endinterface

interface bfp_result_if;
  import bfp_pkg::*;
  logic                valid;
  logic                ready;
  logic                byte_valid;
  logic [7:0]          data_byte;
  logic [AddrBits-1:0] byte_address;
  logic                overflow;
  logic                last;
  modport source (output valid, output byte_valid, output data_byte, output byte_address,
                  output overflow, output last, input ready);
  modport sink (input valid, input byte_valid, input data_byte, input byte_address,
                input overflow, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bit_field_packer_lsb_first.sv =====
// LSB-first bit-field packer: appends 0..32-bit fields to a byte stream.
// Each accepted input word loads a result register, and its results are
// emitted one per cycle while result.ready is high: a write gives one result
// per completed byte (1 to 4 results), or one with byte_valid low if no byte
// completes; a finalize or a dropped write gives one result. The output port
// moving one result a cycle sets the rate; a new word is accepted in the same
// cycle that the last result of the previous one is taken. Writes that would
// pass capacity_bytes*8 bits are dropped and set the sticky overflow flag,
// which a finalize reports and clears along with the bit position.
`default_nettype none
module bit_field_packer_lsb_first #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int ADDR_BITS      = 16
) (
  input  logic         clk,
  input  logic         rst,
  bfp_cfg_if.sink      cfg,
  bfp_item_if.sink     item,
  bfp_result_if.source result
);
  import bfp_pkg::*;

  localparam int WidthLimitInt = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
  localparam logic [WidthBits-1:0] WidthLimit = WidthBits'(WidthLimitInt);
  localparam logic [AddrBits-1:0] AddrMask =
    (ADDR_BITS >= AddrBits) ? {AddrBits{1'b1}} : AddrBits'((1 << ADDR_BITS) - 1);

  logic [CapBits-1:0]  capacity;
  logic [PosBits-1:0]  bits_written;
  logic [PendBits-1:0] pending;
  logic                overflow_seen;
  grp_t                grp;
  logic                grp_valid;
  logic [1:0]          idx;

  logic [PosBits-1:0]  bits_written_next;
  logic [PendBits-1:0] pending_next;
  logic                overflow_next;
  grp_t                grp_next;

  logic [2:0]           r;
  logic [WidthBits-1:0] width_sat;
  logic [PosBits:0]     sum;
  logic                 no_room;
  logic [ValueBits-1:0] masked;
  logic [39:0]          acc;
  logic [39:0]          acc_rest;
  logic [6:0]           total;
  logic [2:0]           n;
  logic                 at_last;
  logic                 take;
  logic                 pop;

  assign r         = bits_written[2:0];
  assign width_sat = (item.field_width > WidthLimit) ? WidthLimit : item.field_width;
  assign sum       = {1'b0, bits_written} + (PosBits + 1)'(width_sat);
  assign no_room   = sum > {1'b0, capacity, 3'b000};
  assign masked    = item.field_value & ~({ValueBits{1'b1}} << width_sat);
  assign acc       = ({8'b0, masked} << r) | {33'b0, pending};
  assign total     = 7'(r) + 7'(width_sat);
  assign n         = total[5:3];
  assign acc_rest  = acc >> {n, 3'b000};

  always_comb begin
    bits_written_next  = bits_written;
    pending_next       = pending;
    overflow_next      = overflow_seen;
    grp_next.has_bytes = 1'b0;
    grp_next.ovf       = overflow_seen;
    grp_next.last_idx  = 2'd0;
    grp_next.base      = bits_written[PosBits-1:3];
    grp_next.bytes     = acc[31:0];
    if (item.kind) begin
      grp_next.has_bytes = (r != 3'd0);
      grp_next.bytes     = {25'b0, pending};
      bits_written_next  = '0;
      pending_next       = '0;
      overflow_next      = 1'b0;
    end else if (no_room) begin
      grp_next.ovf  = 1'b1;
      overflow_next = 1'b1;
    end else begin
      grp_next.has_bytes = (n != 3'd0);
      grp_next.last_idx  = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
      bits_written_next  = sum[PosBits-1:0];
      pending_next       = acc_rest[PendBits-1:0];
    end
  end

  assign at_last    = (idx == grp.last_idx);
  assign pop        = result.valid && result.ready;
  assign item.ready = !grp_valid || (result.ready && at_last);
  assign take       = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= {CapBits{1'b1}};
      bits_written  <= '0;
      pending       <= '0;
      overflow_seen <= 1'b0;
      grp_valid     <= 1'b0;
      idx           <= 2'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        capacity <= cfg.data;
      end
      if (take) begin
        bits_written  <= bits_written_next;
        pending       <= pending_next;
        overflow_seen <= overflow_next;
        grp_valid     <= 1'b1;
        idx           <= 2'd0;
      end else if (pop) begin
        if (at_last) begin
          grp_valid <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      grp <= grp_next;
    end
  end

  assign result.valid        = grp_valid;
  assign result.byte_valid   = grp.has_bytes;
  assign result.data_byte    = grp.has_bytes ? grp.bytes[idx] : 8'd0;
  assign result.byte_address = grp.has_bytes ? ((grp.base + AddrBits'(idx)) & AddrMask)
                                             : '0;
  assign result.overflow     = grp.ovf;
  assign result.last         = at_last;

endmodule
`default_nettype wire
